### src/cubic_self_avoiding_walk_enumerator_defines.svh
`ifndef CUBIC_SELF_AVOIDING_WALK_ENUMERATOR_DEFINES_SVH
`define CUBIC_SELF_AVOIDING_WALK_ENUMERATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CSAW_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("csaw check failed: same-cycle rule");

// next-cycle implication, sampled on clk, off during reset
`define CSAW_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("csaw check failed: next-cycle rule");

`endif

### src/csaw_pkg.sv
package csaw_pkg;

    localparam int MAX_BONDS  = 15;
    localparam int NCELL      = MAX_BONDS + 1;
    localparam int HW         = $clog2(NCELL);
    localparam int CFG_W      = 4;
    localparam int EW         = (HW > CFG_W) ? HW : CFG_W;
    localparam int COORD_W    = 6;
    localparam int DIR_W      = 3;
    localparam int WALK_W     = 45;
    localparam int WALK_BONDS = WALK_W / DIR_W;
    localparam int PACK_N     = (WALK_BONDS < MAX_BONDS) ? WALK_BONDS : MAX_BONDS;
    localparam int TOTAL_W    = 40;

    localparam logic [CFG_W-1:0] BONDS_RESET = CFG_W'(11);

    typedef logic [DIR_W-1:0] dir_t;

    localparam dir_t DIR_PX   = DIR_W'(0);
    localparam dir_t DIR_PY   = DIR_W'(1);
    localparam dir_t DIR_PZ   = DIR_W'(2);
    localparam dir_t DIR_MZ   = DIR_W'(3);
    localparam dir_t DIR_MY   = DIR_W'(4);
    localparam dir_t DIR_MX   = DIR_W'(5);
    localparam dir_t DIR_OVER = DIR_W'(6);
    localparam dir_t DIR_NONE = DIR_W'(7);

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } site_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } probe_t;

    typedef struct packed {
        logic clear;
        logic site_we;
        logic dir_we;
        logic check;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_BUMP
    } state_t;

    function automatic logic [HW-1:0] eff_bonds(input logic [CFG_W-1:0] raw);
        logic [EW-1:0] v;
        v = EW'(raw);
        if (v == '0)
        begin
            v = EW'(1);
        end
        if (v > EW'(MAX_BONDS))
        begin
            v = EW'(MAX_BONDS);
        end
        return HW'(v);
    endfunction

endpackage

### src/csaw_cell.sv
module csaw_cell
    import csaw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  site_t     site_in,
    input  dir_t      dir_in,
    input  site_t     end_site,
    input  probe_t    probe_in,
    output probe_t    probe_out,
    output site_t     site,
    output dir_t      dir
);

    site_t  site_reg, site_next;
    dir_t   dir_reg, dir_next;
    probe_t probe_reg, probe_next;
    logic   match;

    always_comb
    begin
        match            = ctl.check && probe_in.valid && (site_reg == end_site);
        probe_next.valid = probe_in.valid && !ctl.clear;
        probe_next.hit   = (probe_in.hit || match) && !ctl.clear;
        site_next        = ctl.site_we ? site_in : site_reg;
        if (ctl.clear)
        begin
            dir_next = DIR_NONE;
        end
        else if (ctl.dir_we)
        begin
            dir_next = dir_in;
        end
        else
        begin
            dir_next = dir_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            site_reg  <= '0;
            dir_reg   <= DIR_NONE;
            probe_reg <= '0;
        end
        else
        begin
            site_reg  <= site_next;
            dir_reg   <= dir_next;
            probe_reg <= probe_next;
        end
    end

    assign probe_out = probe_reg;
    assign site      = site_reg;
    assign dir       = dir_reg;

endmodule

### src/cubic_self_avoiding_walk_enumerator.sv
// Self-avoiding walk search on the cubic lattice, one search iteration per command.
// Command channel: pulse start while busy is low; restart=1 clears the search and the
// count and yields no result, restart=0 runs one iteration.
// Configuration: cfg_write with cfg_data sets the bond count and clears the search.
// Result channel: valid is high for exactly one cycle with walk_directions, walks_found
// and finished; there is no back-pressure, so take the beat in that cycle.
// An iteration at search depth d (0..MAX_BONDS-1) has an accept step, then the collision
// probe walking down the row of site cells to cell 0, then backtracking one level at a
// time. The result beat comes with busy falling, and a new command may be given in that
// same cycle.
// Restart and advance-after-finish commands leave busy low.
// Reset: bond count 11, search at the first walk, count zero.
module cubic_self_avoiding_walk_enumerator
    import csaw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               restart,
    input  logic               cfg_write,
    input  logic [CFG_W-1:0]   cfg_data,
    output logic               valid,
    output logic [WALK_W-1:0]  walk_directions,
    output logic [TOTAL_W-1:0] walks_found,
    output logic               finished
);

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   bonds_reg, bonds_next;
    logic [HW-1:0]      head_reg, head_next;
    logic [HW-1:0]      lvl_reg, lvl_next;
    logic [HW-1:0]      fy_reg, fy_next;
    logic [HW-1:0]      fz_reg, fz_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               done_reg, done_next;
    logic               found_reg, found_next;
    logic               valid_reg, valid_next;
    logic [WALK_W-1:0]  walk_reg, walk_next;
    site_t              end_reg, end_next;

    site_t     cell_site [NCELL];
    dir_t      cell_dir  [NCELL];
    dir_t      dir_vec   [NCELL];
    probe_t    link      [NCELL+1];
    probe_t    cell_in   [NCELL];
    cell_ctl_t ctl       [NCELL];

    logic [HW-1:0]     b;
    logic              accept;
    logic              clear_all;
    logic              step_go;
    logic [HW-1:0]     h_new;
    site_t             new_end;
    dir_t              bd, bd1;
    logic [HW-1:0]     bfy, bfz;
    logic              overflow;
    logic              at_end;
    logic              found;
    logic              back;
    logic              finish;
    logic [WALK_W-1:0] packed_walk;
    dir_t              dir_wr;

    function automatic site_t step_site(input site_t s, input dir_t d);
        site_t r;
        r = s;
        case (d)
            DIR_PX:  r.x = s.x + coord_t'(1);
            DIR_PY:  r.y = s.y + coord_t'(1);
            DIR_PZ:  r.z = s.z + coord_t'(1);
            DIR_MZ:  r.z = s.z - coord_t'(1);
            DIR_MY:  r.y = s.y - coord_t'(1);
            DIR_MX:  r.x = s.x - coord_t'(1);
            default: r = s;
        endcase
        return r;
    endfunction

    assign b         = eff_bonds(bonds_reg);
    assign accept    = start && (state_reg == ST_IDLE);
    assign clear_all = cfg_write || (accept && restart);
    assign step_go   = accept && !restart && !cfg_write && !done_reg && (head_reg < b);
    assign h_new     = head_reg + HW'(1);
    assign new_end   = step_site(cell_site[head_reg], dir_vec[head_reg]);
    assign link[NCELL] = '0;

    genvar i;
    generate
        for (i = 0; i < NCELL; i++)
        begin : g_cell
            always_comb
            begin
                ctl[i].clear   = clear_all;
                ctl[i].site_we = step_go && (h_new == HW'(i));
                ctl[i].dir_we  = (state_reg == ST_BUMP) && !cfg_write
                                 && (lvl_reg == HW'(i)) && (lvl_reg != '0);
                ctl[i].check   = (state_reg == ST_SCAN) && (lvl_reg[0] == 1'(i % 2));
                if (step_go && (head_reg == HW'(i)))
                begin
                    cell_in[i] = '{valid: 1'b1, hit: 1'b0};
                end
                else
                begin
                    cell_in[i] = link[i+1];
                end
            end

            csaw_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl[i]),
                .site_in   (new_end),
                .dir_in    (dir_wr),
                .end_site  (end_reg),
                .probe_in  (cell_in[i]),
                .probe_out (link[i]),
                .site      (cell_site[i]),
                .dir       (cell_dir[i])
            );

            if (i == 0)
            begin : g_anchor
                assign dir_vec[i] = DIR_PX;
            end
            else
            begin : g_free
                assign dir_vec[i] = cell_dir[i];
            end
        end
    endgenerate

    always_comb
    begin
        bd  = dir_vec[lvl_reg];
        bfy = fy_reg;
        bfz = fz_reg;
        if (fy_reg > lvl_reg)
        begin
            bfy = lvl_reg;
            bfz = '0;
        end
        else if ((fz_reg > lvl_reg) && (bd == DIR_PY))
        begin
            bfz = lvl_reg;
        end
        bd1 = bd + DIR_W'(1);
        if ((bd1 == DIR_MZ) && (bfz == lvl_reg))
        begin
            bd1 = DIR_MY;
            bfz = '0;
        end
        else if ((bd1 > DIR_PY) && (bfy == lvl_reg))
        begin
            bd1 = DIR_OVER;
        end
        overflow = bd1 > DIR_MX;
        dir_wr   = overflow ? DIR_NONE : bd1;
        finish   = (lvl_reg == '0) || !overflow || (lvl_reg == HW'(1));
    end

    always_comb
    begin
        packed_walk = '0;
        for (int k = 0; k < PACK_N; k++)
        begin
            if (HW'(k) < b)
            begin
                packed_walk[DIR_W*k +: DIR_W] = dir_vec[k];
            end
        end
        at_end = lvl_reg == b;
        found  = !link[0].hit && at_end;
        back   = link[0].hit || at_end;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (step_go)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cfg_write)
                begin
                    state_next = ST_IDLE;
                end
                else if (link[0].valid)
                begin
                    state_next = ST_BUMP;
                end
            end
            ST_BUMP:
            begin
                if (cfg_write || finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        bonds_next = bonds_reg;
        head_next  = head_reg;
        lvl_next   = lvl_reg;
        fy_next    = fy_reg;
        fz_next    = fz_reg;
        total_next = total_reg;
        done_next  = done_reg;
        found_next = found_reg;
        valid_next = 1'b0;
        walk_next  = walk_reg;
        end_next   = end_reg;
        if (clear_all)
        begin
            if (cfg_write)
            begin
                bonds_next = cfg_data;
            end
            head_next  = '0;
            lvl_next   = '0;
            fy_next    = '0;
            fz_next    = '0;
            total_next = '0;
            done_next  = 1'b0;
            found_next = 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && !done_reg)
                    begin
                        if (head_reg >= b)
                        begin
                            done_next  = 1'b1;
                            valid_next = 1'b1;
                            walk_next  = '0;
                        end
                        else
                        begin
                            end_next = new_end;
                            lvl_next = h_new;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (link[0].valid)
                    begin
                        found_next = found;
                        walk_next  = '0;
                        if (found)
                        begin
                            if (fy_reg == '0)
                            begin
                                fy_next = b - HW'(1);
                            end
                            if (fz_reg == '0)
                            begin
                                fz_next = b - HW'(1);
                            end
                            if (total_reg != '1)
                            begin
                                total_next = total_reg + TOTAL_W'(1);
                            end
                            walk_next = packed_walk;
                        end
                        lvl_next = back ? (lvl_reg - HW'(1)) : lvl_reg;
                    end
                end
                ST_BUMP:
                begin
                    if (lvl_reg == '0)
                    begin
                        head_next  = '0;
                        done_next  = 1'b1;
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        fy_next = bfy;
                        fz_next = bfz;
                        if (overflow)
                        begin
                            lvl_next = lvl_reg - HW'(1);
                            if (lvl_reg == HW'(1))
                            begin
                                head_next  = '0;
                                done_next  = 1'b1;
                                valid_next = 1'b1;
                            end
                        end
                        else
                        begin
                            head_next  = lvl_reg;
                            valid_next = found_reg;
                        end
                    end
                end
                default:
                begin
                    valid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bonds_reg <= BONDS_RESET;
            head_reg  <= '0;
            lvl_reg   <= '0;
            fy_reg    <= '0;
            fz_reg    <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bonds_reg <= bonds_next;
            head_reg  <= head_next;
            lvl_reg   <= lvl_next;
            fy_reg    <= fy_next;
            fz_reg    <= fz_next;
            total_reg <= total_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_reg <= walk_next;
        end_reg  <= end_next;
    end

    assign busy            = state_reg != ST_IDLE;
    assign valid           = valid_reg;
    assign walk_directions = walk_reg;
    assign walks_found     = total_reg;
    assign finished        = done_reg;

endmodule

### src/csaw_checker.sv
`include "cubic_self_avoiding_walk_enumerator_defines.svh"

module csaw_checker
    import csaw_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               restart,
    input logic               cfg_write,
    input logic               valid,
    input logic [WALK_W-1:0]  walk_directions,
    input logic [TOTAL_W-1:0] walks_found,
    input logic               finished
);

    `CSAW_ASSERT_NOW(a_beat_when_idle, valid, !busy)
    `CSAW_ASSERT_NEXT(a_clear_silent, (start && !busy && restart) || cfg_write, !valid)
    `CSAW_ASSERT_NOW(a_walk_counted, valid && !finished, walks_found != '0)
    `CSAW_ASSERT_NOW(a_first_bond_px, valid, walk_directions[DIR_W-1:0] == DIR_PX)

endmodule

bind cubic_self_avoiding_walk_enumerator csaw_checker u_csaw_checker (.*);
